// ===== sv/mopse_pkg.sv =====
// Package for the mono OLED page stream encoder: command codes, job record
// passed from the front end to the byte sequencer, and the power-up table.
// No dependencies.
package mopse_pkg;

  localparam int PAGE_COUNT_DEF      = 8;
  localparam int BLOCKS_PER_PAGE_DEF = 16;

  // input command codes
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_POS   = 2'd1;
  localparam logic [1:0] CMD_BLOCK = 2'd2;

  localparam int PAGE_ADDR_W = 4;
  localparam int COLUMN_W    = 7;

  localparam int INIT_LEN = 25;
  localparam int STEP_W   = $clog2(INIT_LEN);

  localparam logic [STEP_W-1:0] STEP_POS0       = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_POS_LO     = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_POS_HI     = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_DATA0      = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_BLOCK_LAST = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_CONTRAST   = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_INIT_LAST  = STEP_W'(INIT_LEN - 1);

  localparam logic [7:0] SET_PAGE_BASE  = 8'hb0;
  localparam logic [7:0] SET_COL_HI     = 8'h10;
  localparam logic [7:0] COL_LO_MASK    = 8'h0f;
  localparam logic [7:0] CONTRAST_RESET = 8'd102;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // power-up sequence, entry 0 first; the contrast slot is replaced by the register
  localparam logic [INIT_LEN-1:0][7:0] INIT_SEQ = {
    8'haf, 8'h14, 8'h8d, 8'h30, 8'hdb, 8'h12, 8'hda, 8'h1f, 8'hd9, 8'h80,
    8'hd5, 8'h00, 8'hd3, 8'hc8, 8'h3f, 8'ha8, 8'ha6, 8'ha1, 8'h00, 8'h81,
    8'hb0, 8'h40, 8'h10, 8'h00, 8'hae
  };

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_POS,
    JOB_BLOCK
  } job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    logic                  with_pos;  // block job opens with a set-position
    logic [COLUMN_W-1:0]   column;
    logic [PAGE_ADDR_W-1:0] page;
    logic [7:0][7:0]       cols;      // transposed column bytes, cols[0] first
  } job_t;

endpackage

// ===== sv/mopse_front.sv =====
// Front end of the page stream encoder: takes requests, classifies them,
// tracks the page/block counters and transposes pixel blocks. Uses mopse_pkg.
module mopse_front import mopse_pkg::*; #(
  parameter int PAGE_COUNT      = PAGE_COUNT_DEF,
  parameter int BLOCKS_PER_PAGE = BLOCKS_PER_PAGE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             command,
  input  logic [7:0][7:0]        rows,
  input  logic [COLUMN_W-1:0]    pos_column,
  input  logic [2:0]             pos_page,
  input  logic                   q_full,
  output logic                   accept,
  output logic                   push,
  output job_t                   job
);

  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int BLK_W  = (BLOCKS_PER_PAGE > 1) ? $clog2(BLOCKS_PER_PAGE) : 1;

  logic [PAGE_W-1:0] page_index, page_index_next;
  logic [BLK_W-1:0]  block_index, block_index_next;
  logic              is_block;

  assign accept   = in_valid && !q_full;
  assign is_block = (command == CMD_BLOCK);
  // unused command code is swallowed without a job
  assign push     = accept && (command == CMD_INIT || command == CMD_POS || is_block);

  always_comb begin
    job = '0;
    case (command)
      CMD_INIT: begin
        job.kind = JOB_INIT;
      end
      CMD_POS: begin
        job.kind   = JOB_POS;
        job.column = pos_column;
        job.page   = PAGE_ADDR_W'(pos_page);
      end
      default: begin
        job.kind     = JOB_BLOCK;
        job.with_pos = (block_index == '0);
        job.page     = PAGE_ADDR_W'(page_index);
      end
    endcase
    // column byte b holds bit b of row r in bit r
    for (int b = 0; b < 8; b++) begin
      for (int r = 0; r < 8; r++) begin
        job.cols[b][r] = rows[r][b];
      end
    end
  end

  always_comb begin
    page_index_next  = page_index;
    block_index_next = block_index;
    if (accept && is_block) begin
      if (block_index == BLK_W'(BLOCKS_PER_PAGE - 1)) begin
        block_index_next = '0;
        if (page_index == PAGE_W'(PAGE_COUNT - 1)) begin
          page_index_next = '0;
        end else begin
          page_index_next = page_index + PAGE_W'(1);
        end
      end else begin
        block_index_next = block_index + BLK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_index  <= '0;
      block_index <= '0;
    end else begin
      page_index  <= page_index_next;
      block_index <= block_index_next;
    end
  end

endmodule

// ===== sv/mopse_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Uses mopse_pkg for the job record and depth.
module mopse_queue import mopse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== sv/mopse_back.sv =====
// Byte sequencer of the page stream encoder: walks the queue head job one
// byte per cycle, unless out_stall holds it, into the output register;
// holds the contrast register. Uses mopse_pkg.
module mopse_back import mopse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       head_valid,
  input  job_t       head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last_of_run
);

  logic [7:0]        contrast;
  logic [STEP_W-1:0] step, step_next;
  logic              busy, busy_next;
  logic [STEP_W-1:0] cur_step, start_step, last_step;
  logic [2:0]        col_idx;
  logic              out_free, emit, emit_last;
  logic [7:0]        byte_val;
  logic              data_flag;

  assign start_step = (head_job.kind == JOB_BLOCK && !head_job.with_pos)
                      ? STEP_DATA0 : STEP_POS0;
  assign cur_step   = busy ? step : start_step;
  assign col_idx    = 3'(cur_step - STEP_DATA0);

  always_comb begin
    case (head_job.kind)
      JOB_INIT: last_step = STEP_INIT_LAST;
      JOB_POS:  last_step = STEP_POS_HI;
      default:  last_step = STEP_BLOCK_LAST;
    endcase
  end

  assign out_free  = !out_valid || !out_stall;
  assign emit      = head_valid && out_free;
  assign emit_last = emit && (cur_step == last_step);
  assign pop       = emit_last;

  always_comb begin
    data_flag = 1'b0;
    if (head_job.kind == JOB_INIT) begin
      byte_val = (cur_step == STEP_CONTRAST) ? contrast : INIT_SEQ[cur_step];
    end else if (cur_step == STEP_POS0) begin
      byte_val = SET_PAGE_BASE + 8'(head_job.page);
    end else if (cur_step == STEP_POS_LO) begin
      byte_val = 8'(head_job.column) & COL_LO_MASK;
    end else if (cur_step == STEP_POS_HI) begin
      byte_val = SET_COL_HI | 8'(head_job.column[COLUMN_W-1:4]);
    end else begin
      byte_val  = head_job.cols[col_idx];
      data_flag = 1'b1;
    end
  end

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (emit) begin
      busy_next = !emit_last;
      step_next = cur_step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast  <= CONTRAST_RESET;
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        contrast <= cfg_data;
      end
      busy <= busy_next;
      step <= step_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_val;
      is_data     <= data_flag;
      last_of_run <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
      busy |-> step <= STEP_INIT_LAST)
    else $error("sequencer step past end of run");
  a_busy_needs_head: assert property (@(posedge clk) disable iff (rst)
      busy |-> head_valid)
    else $error("sequencer busy without a queued job");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
      emit_last |=> !busy)
    else $error("run did not end on its last byte");
`endif

endmodule

// ===== sv/mono_oled_page_stream_encoder_core.sv =====
// Mono OLED page stream encoder, top level.
// Uses mopse_pkg, mopse_front, mopse_queue, mopse_back.
//
// Input channel (in_valid / in_stall): one request per accepted edge.
//   command 0 emits the 25-byte power-up sequence, 1 a three-byte
//   set-position, 2 transposes rows row0..row7 into eight data bytes,
//   preceded by a set-position to column 0 at the first block of a page.
//   Command 3 is taken and dropped.
// Output channel (out_valid / out_stall): one byte per edge while out_stall
//   is low, with its data/command flag; last_of_run marks the final byte of a request.
// Config channel (cfg_valid / cfg_ready): writes contrast_level; always
//   ready; the user must see it is written only while the block is idle; the block leaves this unchecked.
// Flow: the first byte of a request passes through the job queue and then
//   the output register; the sequencer sends one byte per cycle unless
//   out_stall holds it, so a request sends 3, 8, 11 or 25 bytes. A two-entry
//   job queue lets the next requests be taken while a run is being sent;
//   in_stall rises when it is full.
// Out stall freezes the output register and the sequencer; no byte is lost.
// Reset clears counters, queue and output valid; contrast returns to 102.
module mono_oled_page_stream_encoder_core import mopse_pkg::*; #(
  parameter int PAGE_COUNT      = PAGE_COUNT_DEF,
  parameter int BLOCKS_PER_PAGE = BLOCKS_PER_PAGE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [7:0]          row0_byte,
  input  logic [7:0]          row1_byte,
  input  logic [7:0]          row2_byte,
  input  logic [7:0]          row3_byte,
  input  logic [7:0]          row4_byte,
  input  logic [7:0]          row5_byte,
  input  logic [7:0]          row6_byte,
  input  logic [7:0]          row7_byte,
  input  logic [COLUMN_W-1:0] pos_column,
  input  logic [2:0]          pos_page,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                is_data,
  output logic                last_of_run,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          contrast_level
);

  logic            accept, push, pop, q_full, head_valid;
  job_t            push_job, head_job;
  logic [7:0][7:0] rows;

  assign rows      = {row7_byte, row6_byte, row5_byte, row4_byte,
                      row3_byte, row2_byte, row1_byte, row0_byte};
  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  mopse_front #(
    .PAGE_COUNT      (PAGE_COUNT),
    .BLOCKS_PER_PAGE (BLOCKS_PER_PAGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .command    (command),
    .rows       (rows),
    .pos_column (pos_column),
    .pos_page   (pos_page),
    .q_full     (q_full),
    .accept     (accept),
    .push       (push),
    .job        (push_job)
  );

  mopse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mopse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (contrast_level),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_data     (is_data),
    .last_of_run (last_of_run)
  );

`ifndef SYNTHESIS
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst) push |-> accept)
    else $error("job queued without an accepted request");
  a_drop_unused: assert property (@(posedge clk) disable iff (rst)
      (accept && command != CMD_INIT && command != CMD_POS && command != CMD_BLOCK)
      |-> !push)
    else $error("unused command produced a job");
  a_out_after_job: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(head_valid))
    else $error("output byte without a queued job");
`endif

endmodule
